@@ rtl/psb_pkg.sv @@
// ----------------------------------------------------------------------------
// psb_pkg: shared types of the topic broker
// Command and status codes, word layouts, state encoding and the control
// and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package psb_pkg;

	typedef enum logic [1:0] {
		CMD_SUBSCRIBE   = 2'd0,
		CMD_UNSUBSCRIBE = 2'd1,
		CMD_PUBLISH     = 2'd2,
		CMD_DISPATCH    = 2'd3
	} psb_cmd_t;

	typedef enum logic [2:0] {
		ST_OK             = 3'd0,
		ST_BAD_TOPIC      = 3'd1,
		ST_TOPIC_FULL     = 3'd2,
		ST_NOT_SUBSCRIBED = 3'd3,
		ST_QUEUE_FULL     = 3'd4,
		ST_DELIVERY       = 3'd5,
		ST_QUEUE_EMPTY    = 3'd6,
		ST_NO_RECEIVER    = 3'd7
	} psb_status_t;

	localparam logic [7:0] BCAST_RESET = 8'd1;

	typedef struct packed {
		psb_cmd_t    cmd;
		logic [15:0] topic;
		logic [7:0]  subscriber;
		logic [7:0]  group;
		logic [7:0]  handler_tag;
		logic [31:0] payload;
	} psb_in_t;

	typedef struct packed {
		psb_status_t status;
		logic [7:0]  target;
		logic [7:0]  handler_out;
		logic [7:0]  topic_out;
		logic [31:0] data_out;
		logic        last;
	} psb_out_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_CNT_RD,
		S_CNT_EVAL,
		S_SCAN,
		S_SHIFT
	} psb_state_t;

	typedef struct packed {
		logic        load;
		logic        clr_step;
		logic        dq;
		logic        pub;
		logic        row_from_req;
		logic        sub_write;
		logic        cnt_dec;
		logic        scan_init;
		logic        scan_step;
		logic        pend_load;
		logic        shift_init;
		logic        shift_step;
		logic        emit;
		logic        emit_deliv;
		logic        emit_last;
		psb_status_t emit_status;
	} psb_ctl_t;

	typedef struct packed {
		psb_cmd_t op;
		logic     clr_last;
		logic     topic_bad;
		logic     fill_zero;
		logic     q_full;
		logic     cnt_full;
		logic     scan_end;
		logic     match_grp;
		logic     match_sub;
		logic     pend_vld;
		logic     shift_end;
	} psb_sts_t;

endpackage

@@ rtl/psb_dp.sv @@
// ----------------------------------------------------------------------------
// psb_dp: broker datapath
// Count, slot and queue memories, the scan and shift counters, the pending
// delivery and the result register.
// ----------------------------------------------------------------------------
module psb_dp #(
	parameter int TOPICS      = 256,
	parameter int SLOTS       = 8,
	parameter int QUEUE_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  psb_pkg::psb_in_t   req,
	input  logic               cfg_valid,
	input  logic [7:0]         cfg_data,
	input  psb_pkg::psb_ctl_t  ctl,
	output psb_pkg::psb_sts_t  sts,
	output psb_pkg::psb_out_t  rsp,
	output logic               rsp_valid
);

	localparam int TW = $clog2(TOPICS);
	localparam int CW = $clog2(SLOTS + 1);
	localparam int AW = $clog2(TOPICS * SLOTS);
	localparam int QW = $clog2(QUEUE_DEPTH);
	localparam int FW = $clog2(QUEUE_DEPTH + 1);
	localparam int QDW = TW + 40;

	psb_pkg::psb_in_t req_q;
	logic [7:0]     bcast_q;
	logic [TW-1:0]  row_q;
	logic [31:0]    data_q;
	logic [7:0]     mgrp_q;
	logic [CW-1:0]  cnt_mem [TOPICS];
	logic [CW-1:0]  cnt_rd_q;
	logic [TW-1:0]  clr_q;
	logic [23:0]    slot_mem [TOPICS*SLOTS];
	logic [23:0]    slot_rd_q;
	logic [QDW-1:0] q_mem [QUEUE_DEPTH];
	logic [QDW-1:0] q_rd_q;
	logic [QW-1:0]  rptr_q, wptr_q;
	logic [FW-1:0]  fill_q;
	logic [CW-1:0]  idx_q, rd_idx_q, j_q, sh_dst_q;
	logic           rd_vld_q, sh_vld_q, pend_vld_q;
	logic [7:0]     pend_sub_q, pend_hdl_q;
	psb_pkg::psb_out_t rsp_q;
	logic           rsp_vld_q;
	logic [AW-1:0]  slot_raddr;
	logic           more;
	logic [15:0]    row16;

	function automatic logic [AW-1:0] slot_addr(input logic [TW-1:0] row,
		input logic [CW-1:0] idx);
		slot_addr = AW'(AW'(row) * AW'(SLOTS) + AW'(idx));
	endfunction

	function automatic logic [QW-1:0] ptr_inc(input logic [QW-1:0] p);
		ptr_inc = (p == QW'(QUEUE_DEPTH - 1)) ? '0 : QW'(p + 1'b1);
	endfunction

	assign more  = ((CW+1)'(j_q) + 1'b1) < (CW+1)'(cnt_rd_q);
	assign row16 = 16'(row_q);
	assign slot_raddr = ctl.shift_step ? slot_addr(row_q, CW'(j_q + 1'b1))
	                                   : slot_addr(row_q, CW'(idx_q - 1'b1));

	always_comb begin
		sts.op        = req_q.cmd;
		sts.clr_last  = (clr_q == TW'(TOPICS - 1));
		sts.topic_bad = 32'(req_q.topic) >= 32'(TOPICS);
		sts.fill_zero = (fill_q == '0);
		sts.q_full    = (fill_q == FW'(QUEUE_DEPTH));
		sts.cnt_full  = (cnt_rd_q >= CW'(SLOTS));
		sts.scan_end  = (idx_q == '0) && !rd_vld_q;
		sts.match_grp = rd_vld_q && ((slot_rd_q[15:8] == mgrp_q) || (mgrp_q == bcast_q));
		sts.match_sub = rd_vld_q && (slot_rd_q[23:16] == req_q.subscriber);
		sts.pend_vld  = pend_vld_q;
		sts.shift_end = !more && !sh_vld_q;
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcast_q    <= psb_pkg::BCAST_RESET;
			clr_q      <= '0;
			rptr_q     <= '0;
			wptr_q     <= '0;
			fill_q     <= '0;
			rd_vld_q   <= 1'b0;
			sh_vld_q   <= 1'b0;
			pend_vld_q <= 1'b0;
			rsp_vld_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				bcast_q <= cfg_data;
			end
			if (ctl.clr_step) begin
				clr_q <= TW'(clr_q + 1'b1);
			end
			if (ctl.dq) begin
				rptr_q <= ptr_inc(rptr_q);
				fill_q <= FW'(fill_q - 1'b1);
			end
			if (ctl.pub) begin
				wptr_q <= ptr_inc(wptr_q);
				fill_q <= FW'(fill_q + 1'b1);
			end
			if (ctl.scan_init) begin
				rd_vld_q   <= 1'b0;
				pend_vld_q <= 1'b0;
			end else if (ctl.scan_step) begin
				rd_vld_q <= (idx_q != '0);
			end
			if (ctl.pend_load) begin
				pend_vld_q <= 1'b1;
			end
			if (ctl.shift_init) begin
				sh_vld_q <= 1'b0;
			end else if (ctl.shift_step) begin
				sh_vld_q <= more;
			end
			rsp_vld_q <= ctl.emit;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			req_q <= req;
		end
		if (ctl.row_from_req) begin
			row_q <= req_q.topic[TW-1:0];
		end
		if (ctl.dq) begin
			row_q  <= q_rd_q[QDW-1:40];
			data_q <= q_rd_q[39:8];
			mgrp_q <= q_rd_q[7:0];
		end
		if (ctl.scan_init) begin
			idx_q <= cnt_rd_q;
		end else if (ctl.scan_step && (idx_q != '0)) begin
			idx_q    <= CW'(idx_q - 1'b1);
			rd_idx_q <= CW'(idx_q - 1'b1);
		end
		if (ctl.pend_load) begin
			pend_sub_q <= slot_rd_q[23:16];
			pend_hdl_q <= slot_rd_q[7:0];
		end
		if (ctl.shift_init) begin
			j_q <= rd_idx_q;
		end else if (ctl.shift_step && more) begin
			j_q      <= CW'(j_q + 1'b1);
			sh_dst_q <= j_q;
		end
		if (ctl.emit) begin
			if (ctl.emit_deliv) begin
				rsp_q.status      <= psb_pkg::ST_DELIVERY;
				rsp_q.target      <= pend_sub_q;
				rsp_q.handler_out <= pend_hdl_q;
				rsp_q.topic_out   <= row16[7:0];
				rsp_q.data_out    <= data_q;
				rsp_q.last        <= ctl.emit_last;
			end else begin
				rsp_q.status      <= ctl.emit_status;
				rsp_q.target      <= '0;
				rsp_q.handler_out <= '0;
				rsp_q.topic_out   <= '0;
				rsp_q.data_out    <= '0;
				rsp_q.last        <= 1'b1;
			end
		end
	end

	// Subscription count per topic.
	always_ff @(posedge clk) begin
		if (ctl.clr_step) begin
			cnt_mem[clr_q] <= '0;
		end else if (ctl.sub_write) begin
			cnt_mem[row_q] <= CW'(cnt_rd_q + 1'b1);
		end else if (ctl.cnt_dec) begin
			cnt_mem[row_q] <= CW'(cnt_rd_q - 1'b1);
		end
		cnt_rd_q <= cnt_mem[row_q];
	end

	// Subscription slots, one row of SLOTS words per topic.
	always_ff @(posedge clk) begin
		if (ctl.sub_write) begin
			slot_mem[slot_addr(row_q, cnt_rd_q)] <=
				{req_q.subscriber, req_q.group, req_q.handler_tag};
		end else if (sh_vld_q) begin
			slot_mem[slot_addr(row_q, sh_dst_q)] <= slot_rd_q;
		end
		slot_rd_q <= slot_mem[slot_raddr];
	end

	// Message queue.
	always_ff @(posedge clk) begin
		if (ctl.pub) begin
			q_mem[wptr_q] <= {req_q.topic[TW-1:0], req_q.payload, req_q.group};
		end
		q_rd_q <= q_mem[rptr_q];
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_vld_q;

endmodule

@@ rtl/psb_ctrl.sv @@
// ----------------------------------------------------------------------------
// psb_ctrl: broker controller
// Sequences the clearing pass and each command through the datapath.
// ----------------------------------------------------------------------------
module psb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  psb_pkg::psb_sts_t sts,
	output psb_pkg::psb_ctl_t ctl
);

	psb_pkg::psb_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= psb_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != psb_pkg::S_IDLE);

	always_comb begin
		ctl           = '0;
		ctl.emit_last = 1'b1;
		state_d       = state_q;
		unique case (state_q)
			psb_pkg::S_CLEAR: begin
				ctl.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = psb_pkg::S_IDLE;
				end
			end
			psb_pkg::S_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					state_d  = psb_pkg::S_DECODE;
				end
			end
			psb_pkg::S_DECODE: begin
				state_d = psb_pkg::S_IDLE;
				priority if (sts.op == psb_pkg::CMD_DISPATCH) begin
					if (sts.fill_zero) begin
						ctl.emit        = 1'b1;
						ctl.emit_status = psb_pkg::ST_QUEUE_EMPTY;
					end else begin
						ctl.dq  = 1'b1;
						state_d = psb_pkg::S_CNT_RD;
					end
				end else if (sts.topic_bad) begin
					ctl.emit        = 1'b1;
					ctl.emit_status = psb_pkg::ST_BAD_TOPIC;
				end else if (sts.op == psb_pkg::CMD_PUBLISH) begin
					ctl.emit = 1'b1;
					if (sts.q_full) begin
						ctl.emit_status = psb_pkg::ST_QUEUE_FULL;
					end else begin
						ctl.pub         = 1'b1;
						ctl.emit_status = psb_pkg::ST_OK;
					end
				end else begin
					ctl.row_from_req = 1'b1;
					state_d          = psb_pkg::S_CNT_RD;
				end
			end
			psb_pkg::S_CNT_RD: begin
				state_d = psb_pkg::S_CNT_EVAL;
			end
			psb_pkg::S_CNT_EVAL: begin
				if (sts.op == psb_pkg::CMD_SUBSCRIBE) begin
					ctl.emit = 1'b1;
					state_d  = psb_pkg::S_IDLE;
					if (sts.cnt_full) begin
						ctl.emit_status = psb_pkg::ST_TOPIC_FULL;
					end else begin
						ctl.sub_write   = 1'b1;
						ctl.emit_status = psb_pkg::ST_OK;
					end
				end else begin
					ctl.scan_init = 1'b1;
					state_d       = psb_pkg::S_SCAN;
				end
			end
			psb_pkg::S_SCAN: begin
				if (sts.op == psb_pkg::CMD_UNSUBSCRIBE) begin
					priority if (sts.match_sub) begin
						ctl.shift_init = 1'b1;
						state_d        = psb_pkg::S_SHIFT;
					end else if (sts.scan_end) begin
						ctl.emit        = 1'b1;
						ctl.emit_status = psb_pkg::ST_NOT_SUBSCRIBED;
						state_d         = psb_pkg::S_IDLE;
					end else begin
						ctl.scan_step = 1'b1;
					end
				end else if (sts.scan_end) begin
					// Flush the held delivery as the final word, or report no match.
					ctl.emit = 1'b1;
					state_d  = psb_pkg::S_IDLE;
					if (sts.pend_vld) begin
						ctl.emit_deliv = 1'b1;
					end else begin
						ctl.emit_status = psb_pkg::ST_NO_RECEIVER;
					end
				end else begin
					ctl.scan_step = 1'b1;
					if (sts.match_grp) begin
						ctl.pend_load = 1'b1;
						if (sts.pend_vld) begin
							ctl.emit       = 1'b1;
							ctl.emit_deliv = 1'b1;
							ctl.emit_last  = 1'b0;
						end
					end
				end
			end
			psb_pkg::S_SHIFT: begin
				if (sts.shift_end) begin
					ctl.cnt_dec     = 1'b1;
					ctl.emit        = 1'b1;
					ctl.emit_status = psb_pkg::ST_OK;
					state_d         = psb_pkg::S_IDLE;
				end else begin
					ctl.shift_step = 1'b1;
				end
			end
			default: begin
				state_d = psb_pkg::S_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/pubsub_topic_broker.sv @@
// ----------------------------------------------------------------------------
// pubsub_topic_broker: publish/subscribe topic broker
// Per-topic subscription lists, a message queue and a dispatcher that fans a
// queued message out to the matching subscribers, newest first.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low. Busy then stays
// high until the command's last result word has been issued. Results appear
// on rsp for exactly one cycle with rsp_valid high and cannot be held off, so
// the receiver must take every word as it comes. rsp.last marks the final
// word of a command. After reset the block sweeps its subscription-count
// memory to zero, one topic per cycle, and busy stays high until the sweep
// has cleared the last topic, so no command is taken before then. Commands
// run one at a time. A publish, a bad topic and an empty queue are answered
// from the decode state. A subscribe, including one on a full topic, reads
// the topic's count first and then answers. A dispatch reads the count of
// the message's topic and then scans its slots from the newest down: the
// single read port of the slot memory visits one slot per cycle. An
// unsubscribe scans the same way until it finds its entry or passes the
// oldest slot. One that finds its entry k slots from the newest end, k above
// one, then closes the gap: each of the k - 1 newer entries moves down one
// slot per cycle. The broadcast group register may be written through cfg
// at any time the block is idle; cfg_ready is always high.
// ----------------------------------------------------------------------------
module pubsub_topic_broker #(
	parameter int TOPICS      = 256,
	parameter int SLOTS       = 8,
	parameter int QUEUE_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  psb_pkg::psb_in_t  req,
	output psb_pkg::psb_out_t rsp,
	output logic              rsp_valid,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [7:0]        cfg_data
);

	psb_pkg::psb_ctl_t ctl;
	psb_pkg::psb_sts_t sts;

	// Configuration writes are always accepted.
	assign cfg_ready = 1'b1;

	psb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.ctl    (ctl)
	);

	psb_dp #(
		.TOPICS      (TOPICS),
		.SLOTS       (SLOTS),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.ctl       (ctl),
		.sts       (sts),
		.rsp       (rsp),
		.rsp_valid (rsp_valid)
	);

endmodule

@@ rtl/psb_checker.sv @@
// ----------------------------------------------------------------------------
// psb_assert: port-level checks of the topic broker
// Watches the command and result ports and is bound to the top level.
// ----------------------------------------------------------------------------
module psb_assert (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input psb_pkg::psb_out_t rsp,
	input logic              rsp_valid
);

	// An accepted command keeps the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after a command word");

	// Only a delivery can be followed by more words of the same command.
	a_nondeliv_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != psb_pkg::ST_DELIVERY) |-> rsp.last)
		else $error("non-delivery result without last");

	// A word that is not last means the command is still running.
	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.last |-> busy)
		else $error("idle before the last result word");

	// The next command passes through the decode state first, so no word follows a last one.
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.last |=> !rsp_valid)
		else $error("result word directly after a last word");

endmodule

bind pubsub_topic_broker psb_assert u_psb_assert (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.rsp       (rsp),
	.rsp_valid (rsp_valid)
);
